/* src/fhcv_pkg.sv */
// shared types, constants and the hash step for the frame header checker
package fhcv_pkg;

  localparam int HEADER_BYTES = 80;
  localparam int HASHED_BYTES = 64;

  localparam logic [6:0] OFF_VERSION  = 7'd4;
  localparam logic [6:0] OFF_KIND     = 7'd6;
  localparam logic [6:0] OFF_FLAGS    = 7'd8;
  localparam logic [6:0] OFF_RSVD_LO  = 7'd10;
  localparam logic [6:0] OFF_LENGTH   = 7'd12;
  localparam logic [6:0] OFF_SESSION  = 7'd16;
  localparam logic [6:0] OFF_EPOCH    = 7'd24;
  localparam logic [6:0] OFF_PUBLISH  = 7'd32;
  localparam logic [6:0] OFF_BOOT     = 7'd40;
  localparam logic [6:0] OFF_SEQUENCE = 7'd56;
  localparam logic [6:0] OFF_CHECKSUM = 7'd64;
  localparam logic [6:0] OFF_RSVD_HI  = 7'd72;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [32:0] COUNT_MAX = 33'h1_ffff_ffff;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KIND_FIRST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KIND_LAST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KNOWN_FLAGS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNSUP_FLAGS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd6;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INVALID     = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_UNSUPPORTED = 3'd3,
    ST_TOO_LARGE   = 3'd4,
    ST_TRUNCATED   = 3'd5,
    ST_CHECKSUM    = 3'd6
  } status_e;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] kind_first;
    logic [15:0] kind_last;
    logic [15:0] known_flags;
    logic [15:0] unsup_flags;
    logic [31:0] len_cap;
  } cfg_t;

  // running state of one frame, also the summary handed on at its last byte
  typedef struct packed {
    logic [32:0] count;
    logic [63:0] hash;
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] kind;
    logic [15:0] flags;
    logic        rsvd_nonzero;
    logic [31:0] length;
    logic [63:0] session;
    logic [63:0] publisher;
    logic [63:0] seq_no;
    logic [63:0] checksum;
  } frame_sum_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] frame_kind;
    logic [15:0] frame_flags;
    logic [31:0] decl_len;
    logic [63:0] session_tag;
    logic [63:0] publisher_id;
    logic [63:0] sequence_number;
  } result_t;

  localparam frame_sum_t FRAME_CLEAR = '{
    count: '0, hash: FNV_BASIS, magic: '0, version: '0, kind: '0, flags: '0,
    rsvd_nonzero: 1'b0, length: '0, session: '0, publisher: '0, seq_no: '0,
    checksum: '0
  };

  // xor the byte in, then multiply by 2^40 + 0x1b3 as a sum of shifts
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

/* src/fhcv_if.sv */
// valid/ready channel interfaces for frame bytes and results
interface fhcv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface fhcv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] frame_kind;
  logic [15:0] frame_flags;
  logic [31:0] decl_len;
  logic [63:0] session_tag;
  logic [63:0] publisher_id;
  logic [63:0] sequence_number;

  modport source (
    output valid, output status, output frame_kind, output frame_flags,
    output decl_len, output session_tag, output publisher_id,
    output sequence_number, input ready
  );
  modport sink (
    input valid, input status, input frame_kind, input frame_flags,
    input decl_len, input session_tag, input publisher_id,
    input sequence_number, output ready
  );
endinterface

/* src/fhcv_accum.sv */
// per-byte accumulator: byte count, running hash and header field capture
module fhcv_accum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 frame_end_i,
  output fhcv_pkg::frame_sum_t sum_o,
  output logic                 sum_valid_o
);
  import fhcv_pkg::*;

  frame_sum_t state_q, state_d, upd;
  logic [6:0] pos;
  logic       in_hdr;

  assign pos    = state_q.count[6:0];
  assign in_hdr = state_q.count < 33'(HEADER_BYTES);

  always_comb begin
    upd = state_q;
    if (go_i) begin
      if (in_hdr) begin
        priority if (pos < OFF_VERSION) begin
          upd.magic[{pos[1:0], 3'b000} +: 8] = data_byte_i;
        end else if (pos < OFF_KIND) begin
          upd.version[{pos[0], 3'b000} +: 8] = data_byte_i;
        end else if (pos < OFF_FLAGS) begin
          upd.kind[{pos[0], 3'b000} +: 8] = data_byte_i;
        end else if (pos < OFF_RSVD_LO) begin
          upd.flags[{pos[0], 3'b000} +: 8] = data_byte_i;
        end else if (pos < OFF_LENGTH) begin
          if (data_byte_i != 8'd0) upd.rsvd_nonzero = 1'b1;
        end else if (pos < OFF_SESSION) begin
          upd.length[{pos[1:0], 3'b000} +: 8] = data_byte_i;
        end else if (pos < OFF_EPOCH) begin
          upd.session[{pos[2:0], 3'b000} +: 8] = data_byte_i;
        end else if (pos < OFF_PUBLISH) begin
          upd.hash = upd.hash; // epoch, hashed only
        end else if (pos < OFF_BOOT) begin
          upd.publisher[{pos[2:0], 3'b000} +: 8] = data_byte_i;
        end else if (pos < OFF_SEQUENCE) begin
          upd.hash = upd.hash; // boot id and ordinal, hashed only
        end else if (pos < OFF_CHECKSUM) begin
          upd.seq_no[{pos[2:0], 3'b000} +: 8] = data_byte_i;
        end else if (pos < OFF_RSVD_HI) begin
          upd.checksum[{pos[2:0], 3'b000} +: 8] = data_byte_i;
        end else begin
          if (data_byte_i != 8'd0) upd.rsvd_nonzero = 1'b1;
        end
      end
      if (state_q.count < 33'(HASHED_BYTES) || !in_hdr) begin
        upd.hash = fnv_step(state_q.hash, data_byte_i);
      end
      if (state_q.count != COUNT_MAX) begin
        upd.count = state_q.count + 33'd1;
      end
    end
  end

  assign state_d     = (go_i && frame_end_i) ? FRAME_CLEAR : upd;
  assign sum_o       = upd;
  assign sum_valid_o = go_i && frame_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRAME_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && frame_end_i |=> state_q.count == '0 && state_q.hash == FNV_BASIS)
    else $error("frame state not cleared after last byte");
  a_count_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && !frame_end_i && state_q.count == COUNT_MAX |=> state_q.count == COUNT_MAX)
    else $error("byte count wrapped");
`endif

endmodule

/* src/fhcv_judge.sv */
// frame summary register, status checks and result register
module fhcv_judge (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fhcv_pkg::cfg_t       cfg_i,
  input  fhcv_pkg::frame_sum_t sum_i,
  input  logic                 sum_valid_i,
  output logic                 in_ready_o,
  output fhcv_pkg::result_t    res_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i
);
  import fhcv_pkg::*;

  frame_sum_t snap_q;
  logic       snap_v_q, snap_v_d;
  result_t    res_q, res_d;
  logic       out_v_q, out_v_d;
  logic       out_free, snap_go;
  status_e    status;

  assign out_free   = !out_v_q || res_ready_i;
  assign snap_go    = snap_v_q && out_free;
  assign in_ready_o = !snap_v_q || out_free;

  always_comb begin
    priority if (snap_q.count < 33'(HEADER_BYTES)) begin
      status = ST_INVALID;
    end else if (snap_q.magic != cfg_i.magic) begin
      status = ST_INVALID;
    end else if (snap_q.version != cfg_i.version) begin
      status = ST_BAD_VERSION;
    end else if (snap_q.kind < cfg_i.kind_first || snap_q.kind > cfg_i.kind_last) begin
      status = ST_INVALID;
    end else if ((snap_q.flags & ~cfg_i.known_flags) != 16'd0) begin
      status = ST_INVALID;
    end else if ((snap_q.flags & cfg_i.unsup_flags) != 16'd0) begin
      status = ST_UNSUPPORTED;
    end else if (snap_q.rsvd_nonzero) begin
      status = ST_INVALID;
    end else if (snap_q.length > cfg_i.len_cap) begin
      status = ST_TOO_LARGE;
    end else if (snap_q.count != 33'(HEADER_BYTES) + {1'b0, snap_q.length}) begin
      status = ST_TRUNCATED;
    end else if (snap_q.hash != snap_q.checksum) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res_d = res_q;
    if (snap_go) begin
      res_d.status          = status;
      res_d.frame_kind      = snap_q.kind;
      res_d.frame_flags     = snap_q.flags;
      res_d.decl_len        = snap_q.length;
      res_d.session_tag     = snap_q.session;
      res_d.publisher_id    = snap_q.publisher;
      res_d.sequence_number = snap_q.seq_no;
    end
  end

  assign snap_v_d = sum_valid_i || (snap_v_q && !out_free);
  assign out_v_d  = snap_go || (out_v_q && !res_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      snap_v_q <= snap_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (sum_valid_i) snap_q <= sum_i;
    res_q <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = out_v_q;

`ifndef ASSERT_OFF
  a_summary_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_v_q && out_free |=> out_v_q)
    else $error("frame summary lost on its way to the result register");
  a_summary_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_v_q && !out_free |=> snap_v_q && $stable(snap_q))
    else $error("stalled frame summary overwritten");
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !res_ready_i |=> out_v_q && $stable(res_q))
    else $error("stalled result changed");
`endif

endmodule

/* src/frame_header_check_and_verify.sv */
// top level: frame header check and verify with configuration registers
//
// frame_i takes one frame byte per transfer, header first and then payload,
// with frame_end high on the last byte. a 64-bit fnv-1a hash runs over header
// bytes 0..63 and the payload, and header fields are captured as they pass.
// result_o gives one transfer per frame: status plus the captured fields.
// throughput is one byte per cycle while frame_i.ready is high, set by the hash
// register which folds in one byte (xor, then constant multiply as shifted adds)
// per transfer. the last byte's transfer loads the frame summary register, and
// the status checks fill the result register from it once that one is free or
// being taken, which raises result_o.valid.
// when result_o stalls, one finished frame waits in the result register and
// a second in the summary register; while both are held, frame_i.ready stays
// low for every byte until the result register is taken.
// configuration: write cfg_we_i with cfg_idx_i and cfg_wdata_i while idle;
// unknown indices are ignored. reset clears all frame state, empties both
// result stages and loads the register defaults.
module frame_header_check_and_verify (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fhcv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fhcv_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  fhcv_in_if.sink                        frame_i,
  fhcv_out_if.source                     result_o
);
  import fhcv_pkg::*;

  cfg_t       cfg_q, cfg_d;
  frame_sum_t sum;
  logic       sum_valid;
  logic       in_ready;
  logic       byte_go;
  result_t    res;

  // configuration register bank
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAGIC:       cfg_d.magic       = cfg_wdata_i;
        REG_VERSION:     cfg_d.version     = cfg_wdata_i[15:0];
        REG_KIND_FIRST:  cfg_d.kind_first  = cfg_wdata_i[15:0];
        REG_KIND_LAST:   cfg_d.kind_last   = cfg_wdata_i[15:0];
        REG_KNOWN_FLAGS: cfg_d.known_flags = cfg_wdata_i[15:0];
        REG_UNSUP_FLAGS: cfg_d.unsup_flags = cfg_wdata_i[15:0];
        REG_MAX_PAYLOAD: cfg_d.len_cap     = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{magic: 32'd0, version: 16'd1, kind_first: 16'd1, kind_last: 16'd1,
                 known_flags: 16'd3, unsup_flags: 16'd2, len_cap: 32'd65536};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // a byte transfer on the input channel
  assign frame_i.ready = in_ready;
  assign byte_go       = frame_i.valid && in_ready;

  fhcv_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (byte_go),
    .data_byte_i (frame_i.data_byte),
    .frame_end_i (frame_i.frame_end),
    .sum_o       (sum),
    .sum_valid_o (sum_valid)
  );

  fhcv_judge u_judge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .sum_i       (sum),
    .sum_valid_i (sum_valid),
    .in_ready_o  (in_ready),
    .res_o       (res),
    .res_valid_o (result_o.valid),
    .res_ready_i (result_o.ready)
  );

  // result channel payload
  assign result_o.status          = res.status;
  assign result_o.frame_kind      = res.frame_kind;
  assign result_o.frame_flags     = res.frame_flags;
  assign result_o.decl_len        = res.decl_len;
  assign result_o.session_tag     = res.session_tag;
  assign result_o.publisher_id    = res.publisher_id;
  assign result_o.sequence_number = res.sequence_number;

endmodule

/* dv/fhcv_result_check.sv */
// checker: predicts frame results from observed transfers and compares them
module fhcv_result_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fhcv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fhcv_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  fhcv_in_if                              frame_mon,
  fhcv_out_if                             result_mon,
  output int                              errors_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fhcv_pkg::*;

  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
  localparam cfg_t REG_DEFAULTS = '{
    magic: 32'd0, version: 16'd1, kind_first: 16'd1, kind_last: 16'd1,
    known_flags: 16'd3, unsup_flags: 16'd2, len_cap: 32'd65536
  };

  cfg_t        regs;
  logic [32:0] seen_bytes;
  logic [63:0] digest;
  logic [31:0] seen_magic;
  logic [15:0] seen_version;
  logic [15:0] seen_kind;
  logic [15:0] seen_flags;
  logic        seen_rsvd;
  logic [31:0] seen_length;
  logic [63:0] seen_session;
  logic [63:0] seen_publisher;
  logic [63:0] seen_seqno;
  logic [63:0] seen_checksum;
  result_t     expected_frames[$];

  function automatic void restart_frame();
    seen_bytes     = '0;
    digest         = FNV_BASIS;
    seen_magic     = '0;
    seen_version   = '0;
    seen_kind      = '0;
    seen_flags     = '0;
    seen_rsvd      = 1'b0;
    seen_length    = '0;
    seen_session   = '0;
    seen_publisher = '0;
    seen_seqno     = '0;
    seen_checksum  = '0;
  endfunction

  function automatic status_e frame_verdict();
    if (seen_bytes < 33'(HEADER_BYTES)) return ST_INVALID;
    if (seen_magic != regs.magic) return ST_INVALID;
    if (seen_version != regs.version) return ST_BAD_VERSION;
    if (seen_kind < regs.kind_first || seen_kind > regs.kind_last) return ST_INVALID;
    if ((seen_flags & ~regs.known_flags) != 16'h0) return ST_INVALID;
    if ((seen_flags & regs.unsup_flags) != 16'h0) return ST_UNSUPPORTED;
    if (seen_rsvd) return ST_INVALID;
    if (seen_length > regs.len_cap) return ST_TOO_LARGE;
    if (seen_bytes - 33'(HEADER_BYTES) != {1'b0, seen_length}) return ST_TRUNCATED;
    if (digest != seen_checksum) return ST_CHECKSUM;
    return ST_OK;
  endfunction

  // fold one byte into the running frame; the marked byte closes it
  function automatic void take_frame_byte(input logic [7:0] b, input logic last);
    logic [6:0] pos;
    result_t    want;
    pos = seen_bytes[6:0];
    if (seen_bytes < 33'(HEADER_BYTES)) begin
      if (pos < OFF_VERSION) seen_magic[8*pos +: 8] = b;
      else if (pos < OFF_KIND) seen_version[8*(pos-OFF_VERSION) +: 8] = b;
      else if (pos < OFF_FLAGS) seen_kind[8*(pos-OFF_KIND) +: 8] = b;
      else if (pos < OFF_RSVD_LO) seen_flags[8*(pos-OFF_FLAGS) +: 8] = b;
      else if (pos < OFF_LENGTH) seen_rsvd = seen_rsvd | (b != 8'h0);
      else if (pos < OFF_SESSION) seen_length[8*(pos-OFF_LENGTH) +: 8] = b;
      else if (pos < OFF_EPOCH) seen_session[8*(pos-OFF_SESSION) +: 8] = b;
      else if (pos < OFF_PUBLISH) begin
        // epoch: hashed only
      end else if (pos < OFF_BOOT) seen_publisher[8*(pos-OFF_PUBLISH) +: 8] = b;
      else if (pos < OFF_SEQUENCE) begin
        // boot id and ordinal: hashed only
      end else if (pos < OFF_CHECKSUM) seen_seqno[8*(pos-OFF_SEQUENCE) +: 8] = b;
      else if (pos < OFF_RSVD_HI) seen_checksum[8*(pos-OFF_CHECKSUM) +: 8] = b;
      else seen_rsvd = seen_rsvd | (b != 8'h0);
    end
    // checksum word and upper reserved bytes stay out of the hash
    if (seen_bytes < 33'(HASHED_BYTES) || seen_bytes >= 33'(HEADER_BYTES))
      digest = (digest ^ {56'd0, b}) * FNV_PRIME;
    if (seen_bytes != COUNT_MAX) seen_bytes = seen_bytes + 33'd1;
    if (last) begin
      want.status          = frame_verdict();
      want.frame_kind      = seen_kind;
      want.frame_flags     = seen_flags;
      want.decl_len        = seen_length;
      want.session_tag     = seen_session;
      want.publisher_id    = seen_publisher;
      want.sequence_number = seen_seqno;
      expected_frames.push_back(want);
      restart_frame();
    end
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_MAGIC:       regs.magic       = value;
      REG_VERSION:     regs.version     = value[15:0];
      REG_KIND_FIRST:  regs.kind_first  = value[15:0];
      REG_KIND_LAST:   regs.kind_last   = value[15:0];
      REG_KNOWN_FLAGS: regs.known_flags = value[15:0];
      REG_UNSUP_FLAGS: regs.unsup_flags = value[15:0];
      REG_MAX_PAYLOAD: regs.len_cap     = value;
      default: begin
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors_o++;
    end
  endfunction

  function automatic void compare_result();
    result_t want;
    if (expected_frames.size() == 0) begin
      $error("result with no frame awaiting it: status %0d", result_mon.status);
      errors_o++;
      return;
    end
    want = expected_frames.pop_front();
    compare_field("status", 64'(want.status), 64'(result_mon.status));
    compare_field("frame_kind", 64'(want.frame_kind), 64'(result_mon.frame_kind));
    compare_field("frame_flags", 64'(want.frame_flags), 64'(result_mon.frame_flags));
    compare_field("decl_len", 64'(want.decl_len), 64'(result_mon.decl_len));
    compare_field("session_tag", want.session_tag, result_mon.session_tag);
    compare_field("publisher_id", want.publisher_id, result_mon.publisher_id);
    compare_field("sequence_number", want.sequence_number, result_mon.sequence_number);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = REG_DEFAULTS;
      restart_frame();
      expected_frames.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (result_mon.valid && result_mon.ready) compare_result();
      if (frame_mon.valid && frame_mon.ready)
        take_frame_byte(frame_mon.data_byte, frame_mon.frame_end);
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_wdata_i);
      pending_o = expected_frames.size();
    end
  end

endmodule

/* dv/testbench.sv */
// testbench top: clock, reset, register setup, frame stimulus and the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fhcv_pkg::*;

  localparam int ITEM_TARGET  = 1850;   // bytes sent over the whole run, roughly
  localparam int IDLE_PCT     = 38;     // idle chance per cycle on either side
  localparam int STALL_LIMIT  = 4000;   // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 6;      // result path is two stages deep
  localparam int FRAMES_PER_PHASE = 2;
  localparam int OFF_MAGIC = 0;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

  localparam cfg_t REG_DEFAULTS = '{
    magic: 32'd0, version: 16'd1, kind_first: 16'd1, kind_last: 16'd1,
    known_flags: 16'd3, unsup_flags: 16'd2, len_cap: 32'd65536
  };
  // every register at its top value but kind_first at zero, full kind range
  localparam cfg_t REG_ALL_ONES = '{
    magic: 32'hffff_ffff, version: 16'hffff, kind_first: 16'h0, kind_last: 16'hffff,
    known_flags: 16'hffff, unsup_flags: 16'hffff, len_cap: 32'hffff_ffff
  };
  // zero everywhere but kind_first, so the kind range is empty and every kind fails
  localparam cfg_t REG_EDGE = '{
    magic: 32'h0, version: 16'h0, kind_first: 16'hffff, kind_last: 16'h0,
    known_flags: 16'h0, unsup_flags: 16'h0, len_cap: 32'h0
  };

  // ways a generated frame can be damaged
  typedef enum int {
    FLAW_NONE, FLAW_MAGIC, FLAW_VERSION, FLAW_KIND, FLAW_UNKNOWN_FLAG, FLAW_UNSUP_FLAG,
    FLAW_RESERVED, FLAW_TOO_LARGE, FLAW_LENGTH, FLAW_CHECKSUM, FLAW_SHORT, FLAW_NOISE
  } flaw_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_fire;
  logic                  out_fire;
  bit                    quiet;
  int                    errors;
  int                    pending;
  int                    stall_cycles;
  int                    bytes_sent;
  int                    phase;
  cfg_t                  regs_now;
  logic [7:0]            header_img[HEADER_BYTES];
  logic [7:0]            frame_bytes[$];

  fhcv_in_if  frame_if();
  fhcv_out_if result_if();

  frame_header_check_and_verify dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_i     (frame_if),
    .result_o    (result_if)
  );

  fhcv_result_check result_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .frame_mon   (frame_if),
    .result_mon  (result_if),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  always #1 clk_i = ~clk_i;

  // handshakes seen at the rising edge, read back by the drivers at the falling edge
  always @(posedge clk_i) begin
    in_fire  <= frame_if.valid && frame_if.ready;
    out_fire <= result_if.valid && result_if.ready;
  end

  // watchdog: too long without any transfer means the block has hung
  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side back-pressure, switched off during the quiet stretch
  always @(negedge clk_i) begin
    result_if.ready = quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // write the whole register set, plus a stray write to an unmapped index
  task automatic load_regs(input cfg_t c);
    write_reg(REG_MAGIC, c.magic);
    write_reg(REG_VERSION, 32'(c.version));
    write_reg(REG_KIND_FIRST, 32'(c.kind_first));
    write_reg(REG_KIND_LAST, 32'(c.kind_last));
    write_reg(REG_KNOWN_FLAGS, 32'(c.known_flags));
    write_reg(REG_UNSUP_FLAGS, 32'(c.unsup_flags));
    write_reg(REG_MAX_PAYLOAD, c.len_cap);
    write_reg(REG_UNMAPPED, $urandom);
    regs_now = c;
  endtask

  // hold off the sender until every frame has its result, then let the pipe drain
  task automatic settle();
    frame_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      frame_if.valid = 1'b0;
      @(negedge clk_i);
    end
    frame_if.valid     = 1'b1;
    frame_if.data_byte = b;
    frame_if.frame_end = last;
    do @(negedge clk_i); while (!in_fire);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    bytes_sent += frame_bytes.size();
  endtask

  function automatic void put_field(input int off, input logic [63:0] value,
                                    input int width);
    for (int i = 0; i < width; i++) header_img[off + i] = value[8*i +: 8];
  endfunction

  // fnv-1a over header bytes 0..63 and the payload, for well-formed checksums
  function automatic logic [63:0] frame_digest();
    logic [63:0] h;
    h = FNV_BASIS;
    foreach (frame_bytes[i])
      if (i < HASHED_BYTES || i >= HEADER_BYTES) h = (h ^ {56'd0, frame_bytes[i]}) * FNV_PRIME;
    return h;
  endfunction

  // a frame that passes every check under regs_now (kind random if the kind range is empty), then damaged as asked
  function automatic void build_frame(input flaw_e flaw);
    logic [31:0] magic;
    logic [31:0] declared;
    logic [15:0] version;
    logic [15:0] kind;
    logic [15:0] flags;
    logic [32:0] wide;
    logic [63:0] sum;
    int          plen;
    int          sent_len;
    int          pick;
    frame_bytes.delete();
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(100, 1)) frame_bytes.push_back(8'($urandom));
      return;
    end
    // hashed-only fields and the captured ids stay random
    foreach (header_img[i]) header_img[i] = 8'($urandom);
    magic   = regs_now.magic;
    version = regs_now.version;
    if (regs_now.kind_first <= regs_now.kind_last)
      kind = 16'($urandom_range(regs_now.kind_last, regs_now.kind_first));
    else
      kind = 16'($urandom);
    flags = 16'($urandom) & regs_now.known_flags & ~regs_now.unsup_flags;
    // mostly short payloads, now and then a longer one
    plen = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(16);
    if (32'(plen) > regs_now.len_cap) plen = int'(regs_now.len_cap);
    declared = 32'(plen);
    sent_len = plen;
    case (flaw)
      FLAW_MAGIC: begin
        magic ^= 32'h1 << $urandom_range(31);
      end
      FLAW_VERSION: begin
        version ^= 16'h1 << $urandom_range(15);
      end
      FLAW_KIND: begin
        if (regs_now.kind_first != 16'h0 &&
            ($urandom_range(1) == 0 || regs_now.kind_last == 16'hffff))
          kind = 16'($urandom_range(int'(regs_now.kind_first) - 1, 0));
        else if (regs_now.kind_last != 16'hffff)
          kind = 16'($urandom_range(16'hffff, int'(regs_now.kind_last) + 1));
      end
      FLAW_UNKNOWN_FLAG: begin
        if (regs_now.known_flags != 16'hffff) begin
          do pick = $urandom_range(15); while (regs_now.known_flags[pick]);
          flags[pick] = 1'b1;
        end
      end
      FLAW_UNSUP_FLAG: begin
        if (regs_now.unsup_flags != 16'h0) begin
          do pick = $urandom_range(15); while (!regs_now.unsup_flags[pick]);
          flags[pick] = 1'b1;
        end
      end
      FLAW_TOO_LARGE: begin
        wide = {1'b0, regs_now.len_cap} + 33'd1 + 33'($urandom_range(255));
        declared = wide[32] ? 32'hffff_ffff : wide[31:0];
      end
      FLAW_LENGTH: begin
        // either a payload cut short or extra bytes past the declared length
        if (plen > 0 && $urandom_range(1) == 1) sent_len = $urandom_range(plen - 1, 0);
        else sent_len = plen + $urandom_range(4, 1);
      end
      default: begin
      end
    endcase
    put_field(OFF_MAGIC, 64'(magic), 4);
    put_field(OFF_VERSION, 64'(version), 2);
    put_field(OFF_KIND, 64'(kind), 2);
    put_field(OFF_FLAGS, 64'(flags), 2);
    put_field(OFF_RSVD_LO, 64'h0, 2);
    put_field(OFF_LENGTH, 64'(declared), 4);
    put_field(OFF_RSVD_HI, 64'h0, 8);
    if (flaw == FLAW_RESERVED) begin
      // low reserved pair is hashed, the upper eight are not
      pick = $urandom_range(9);
      header_img[pick < 2 ? OFF_RSVD_LO + pick : OFF_RSVD_HI + pick - 2] =
        8'($urandom_range(255, 1));
    end
    foreach (header_img[i]) frame_bytes.push_back(header_img[i]);
    repeat (sent_len) frame_bytes.push_back(8'($urandom));
    sum = frame_digest();
    if (flaw == FLAW_CHECKSUM) sum ^= 64'h1 << $urandom_range(63);
    for (int i = 0; i < 8; i++) frame_bytes[OFF_CHECKSUM + i] = sum[8*i +: 8];
    if (flaw == FLAW_SHORT) begin
      pick = $urandom_range(HEADER_BYTES - 1, 1);
      while (frame_bytes.size() > pick) void'(frame_bytes.pop_back());
    end
  endfunction

  function automatic flaw_e pick_flaw();
    if ($urandom_range(1) == 0) return FLAW_NONE;
    return flaw_e'($urandom_range(int'(FLAW_NOISE), int'(FLAW_MAGIC)));
  endfunction

  function automatic cfg_t random_regs();
    cfg_t c;
    c.magic      = $urandom;
    c.version    = 16'($urandom);
    c.kind_first = 16'($urandom);
    case ($urandom_range(3))
      0: c.kind_last = c.kind_first;
      1: c.kind_last = 16'($urandom);
      default: c.kind_last = c.kind_first + 16'($urandom_range(200));
    endcase
    c.known_flags = 16'($urandom);
    case ($urandom_range(2))
      0: c.unsup_flags = 16'h0;
      1: c.unsup_flags = c.known_flags & 16'($urandom);
      default: c.unsup_flags = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0: c.len_cap = 32'h0;
      1: c.len_cap = 32'($urandom_range(40));
      2: c.len_cap = $urandom;
      default: c.len_cap = 32'hffff_ffff;
    endcase
    return c;
  endfunction

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_MAGIC;
    cfg_wdata_i        = '0;
    frame_if.valid     = 1'b0;
    frame_if.data_byte = 8'h0;
    frame_if.frame_end = 1'b0;
    quiet              = 1'b0;
    regs_now           = REG_DEFAULTS;
    bytes_sent         = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: every flaw once on the reset register values
    for (int f = FLAW_NONE; f <= FLAW_NOISE; f++) begin
      build_frame(flaw_e'(f));
      send_frame();
    end
    // a frame of a single byte
    frame_bytes.delete();
    frame_bytes.push_back(8'hff);
    send_frame();
    // register extremes: all ones, then all zero with an empty kind range
    settle();
    load_regs(REG_ALL_ONES);
    build_frame(FLAW_NONE);
    send_frame();
    build_frame(FLAW_LENGTH);
    send_frame();
    settle();
    load_regs(REG_EDGE);
    build_frame(FLAW_NONE);
    send_frame();
    build_frame(FLAW_TOO_LARGE);
    send_frame();

    // random part: phases of frames, registers changed only while idle
    phase = 0;
    do begin
      settle();
      case (phase % 5)
        2: load_regs(REG_ALL_ONES);
        4: load_regs(REG_EDGE);
        default: load_regs(random_regs());
      endcase
      // one long stretch with no idling on either side
      quiet = (phase == 0);
      repeat (FRAMES_PER_PHASE) begin
        build_frame(pick_flaw());
        send_frame();
      end
      quiet = 1'b0;
      phase++;
    end while (bytes_sent < ITEM_TARGET);

    settle();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/fhcv_pkg.sv
src/fhcv_if.sv
src/fhcv_accum.sv
src/fhcv_judge.sv
src/frame_header_check_and_verify.sv
dv/fhcv_result_check.sv
dv/testbench.sv
